@@ design/scaf_pkg.sv @@
`timescale 1ns / 1ps

package scaf_pkg;

  // widths of the item fields and of the state
  localparam int TIMER_BITS  = 16;
  localparam int TIMEOUT_W   = 16;
  localparam int CMP_W       = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;
  localparam int ADC_W       = 12;
  localparam int SURF_W      = 9;
  localparam int SURF_N      = 3;
  localparam int POS_W       = 8;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  // decoupling queue between decode and execute
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // servo positions
  localparam logic [POS_W-1:0]  POS_MAX      = 8'd180;
  localparam logic [POS_W-1:0]  POS_NEUTRAL  = 8'd90;
  localparam logic [POS_W-1:0]  POS_ZERO     = 8'd0;
  localparam logic [SURF_W-1:0] SURF_NEUTRAL = 9'd90;

  // register reset values: 7.0 V and 6.5 V through the divider, rounded up
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 16'd1000;
  localparam logic [ADC_W-1:0]     LOW_BATT_RST  = 12'd2896;
  localparam logic [ADC_W-1:0]     CRIT_BATT_RST = 12'd2689;

  typedef enum logic [2:0] {
    OP_CONTROL = 3'd0,
    OP_TRIM    = 3'd1,
    OP_ARM     = 3'd2,
    OP_DISARM  = 3'd3,
    OP_TICK    = 3'd4,
    OP_BATTERY = 3'd5
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT   = 2'd0,
    CFG_LOW_BATT  = 2'd1,
    CFG_CRIT_BATT = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_ARMED    = 2'd1,
    EV_DISARMED = 2'd2
  } status_ev_t;

  // classified item kinds
  typedef enum logic [2:0] {
    K_IDLE,
    K_REFRESH,
    K_CONTROL,
    K_TRIM,
    K_ARM,
    K_DISARM,
    K_TICK,
    K_BATTERY
  } kind_t;

  typedef struct packed {
    kind_t                          kind;
    logic [POS_W-1:0]               throttle;
    logic [SURF_N-1:0][SURF_W-1:0]  vals;
    logic                           batt_low;
    logic                           batt_crit;
  } item_t;

  // signed surface sum clamped to the servo range
  function automatic logic [POS_W-1:0] clamp180(input logic signed [SURF_W:0] v);
    logic signed [SURF_W:0] lim;
    lim = $signed((SURF_W+1)'(POS_MAX));
    if (v < 0) begin
      return POS_ZERO;
    end else if (v > lim) begin
      return POS_MAX;
    end
    return v[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] clamp_thr(input logic [POS_W-1:0] t);
    return (t > POS_MAX) ? POS_MAX : t;
  endfunction

endpackage

@@ design/servo_command_arming_failsafe.sv @@
`timescale 1ns / 1ps
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------------
// in       | in_valid / in_ready   | opcode, checksum, throttle, surfaces, adc
// out      | out_valid / out_ready | applied outputs, armed, failsafe, events
// cfg      | cfg_wr_en             | cfg_index, cfg_data (timeout, thresholds)
//
// one item per cycle sustained while out_ready stays high; the accepting edge
// writes the two-entry decode queue, and the execute stage then registers the result
// from the queue head
// synchronous active-low reset puts every register but the queue storage at its power-up value
// a stalled result holds the execute stage; the queue absorbs two more beats
// before in_ready drops

module servo_command_arming_failsafe (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_opcode,
  input  logic                                in_checksum_ok,
  input  logic [scaf_pkg::POS_W-1:0]          in_throttle_value,
  input  logic signed [scaf_pkg::SURF_W-1:0]  in_aileron_value,
  input  logic signed [scaf_pkg::SURF_W-1:0]  in_elevator_value,
  input  logic signed [scaf_pkg::SURF_W-1:0]  in_rudder_value,
  input  logic [scaf_pkg::ADC_W-1:0]          in_battery_raw,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [scaf_pkg::POS_W-1:0]          out_throttle_out,
  output logic [scaf_pkg::POS_W-1:0]          out_aileron_out,
  output logic [scaf_pkg::POS_W-1:0]          out_elevator_out,
  output logic [scaf_pkg::POS_W-1:0]          out_rudder_out,
  output logic                                out_armed,
  output logic                                out_failsafe_active,
  output logic [1:0]                          out_status_event,
  output logic                                out_low_battery_alert,
  output logic                                out_battery_critical,
  input  logic                                cfg_wr_en,
  input  logic [scaf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scaf_pkg::CFG_W-1:0]          cfg_data
);
  import scaf_pkg::*;

  logic [TIMEOUT_W-1:0] timeout_r, timeout_nxt;
  logic [ADC_W-1:0]     low_thr_r, low_thr_nxt;
  logic [ADC_W-1:0]     crit_thr_r, crit_thr_nxt;

  logic  q_full, q_push, q_pop, q_not_empty;
  item_t q_in_item, q_out_item;

  // configuration register decode
  always_comb begin
    timeout_nxt  = timeout_r;
    low_thr_nxt  = low_thr_r;
    crit_thr_nxt = crit_thr_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TIMEOUT:   timeout_nxt  = cfg_data[TIMEOUT_W-1:0];
        CFG_LOW_BATT:  low_thr_nxt  = cfg_data[ADC_W-1:0];
        CFG_CRIT_BATT: crit_thr_nxt = cfg_data[ADC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RST;
      low_thr_r  <= LOW_BATT_RST;
      crit_thr_r <= CRIT_BATT_RST;
    end else begin
      timeout_r  <= timeout_nxt;
      low_thr_r  <= low_thr_nxt;
      crit_thr_r <= crit_thr_nxt;
    end
  end

  // decode side
  scaf_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_checksum_ok    (in_checksum_ok),
    .in_throttle_value (in_throttle_value),
    .in_aileron_value  (in_aileron_value),
    .in_elevator_value (in_elevator_value),
    .in_rudder_value   (in_rudder_value),
    .in_battery_raw    (in_battery_raw),
    .low_thr           (low_thr_r),
    .crit_thr          (crit_thr_r),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_item            (q_in_item)
  );

  // decoupling queue
  scaf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_out_item)
  );

  // execute side
  scaf_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .timeout               (timeout_r),
    .q_not_empty           (q_not_empty),
    .q_item                (q_out_item),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_throttle_out      (out_throttle_out),
    .out_aileron_out       (out_aileron_out),
    .out_elevator_out      (out_elevator_out),
    .out_rudder_out        (out_rudder_out),
    .out_armed             (out_armed),
    .out_failsafe_active   (out_failsafe_active),
    .out_status_event      (out_status_event),
    .out_low_battery_alert (out_low_battery_alert),
    .out_battery_critical  (out_battery_critical)
  );

endmodule

@@ design/scaf_front.sv @@
`timescale 1ns / 1ps

module scaf_front (
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_opcode,
  input  logic                              in_checksum_ok,
  input  logic [scaf_pkg::POS_W-1:0]        in_throttle_value,
  input  logic signed [scaf_pkg::SURF_W-1:0] in_aileron_value,
  input  logic signed [scaf_pkg::SURF_W-1:0] in_elevator_value,
  input  logic signed [scaf_pkg::SURF_W-1:0] in_rudder_value,
  input  logic [scaf_pkg::ADC_W-1:0]        in_battery_raw,
  input  logic [scaf_pkg::ADC_W-1:0]        low_thr,
  input  logic [scaf_pkg::ADC_W-1:0]        crit_thr,
  input  logic                              q_full,
  output logic                              q_push,
  output scaf_pkg::item_t                   q_item
);
  import scaf_pkg::*;

  // accept whenever the queue has a free slot
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // classify the opcode and pre-compute the battery compares
  always_comb begin
    q_item.throttle  = in_throttle_value;
    q_item.vals[0]   = in_aileron_value;
    q_item.vals[1]   = in_elevator_value;
    q_item.vals[2]   = in_rudder_value;
    q_item.batt_low  = in_battery_raw < low_thr;
    q_item.batt_crit = in_battery_raw < crit_thr;
    unique case (in_opcode)
      OP_CONTROL: q_item.kind = in_checksum_ok ? K_CONTROL : K_REFRESH;
      OP_TRIM:    q_item.kind = K_TRIM;
      OP_ARM:     q_item.kind = K_ARM;
      OP_DISARM:  q_item.kind = K_DISARM;
      OP_TICK:    q_item.kind = K_TICK;
      OP_BATTERY: q_item.kind = K_BATTERY;
      default:    q_item.kind = K_IDLE;
    endcase
  end

endmodule

@@ design/scaf_queue.sv @@
`timescale 1ns / 1ps

module scaf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  scaf_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output scaf_pkg::item_t pop_item
);
  import scaf_pkg::*;

  item_t                  mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;
  logic                   do_push, do_pop;

  assign full      = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count lost a push");
`endif

endmodule

@@ design/scaf_back.sv @@
`timescale 1ns / 1ps

module scaf_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [scaf_pkg::TIMEOUT_W-1:0]     timeout,
  input  logic                               q_not_empty,
  input  scaf_pkg::item_t                    q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [scaf_pkg::POS_W-1:0]         out_throttle_out,
  output logic [scaf_pkg::POS_W-1:0]         out_aileron_out,
  output logic [scaf_pkg::POS_W-1:0]         out_elevator_out,
  output logic [scaf_pkg::POS_W-1:0]         out_rudder_out,
  output logic                               out_armed,
  output logic                               out_failsafe_active,
  output logic [1:0]                         out_status_event,
  output logic                               out_low_battery_alert,
  output logic                               out_battery_critical
);
  import scaf_pkg::*;

  // command state
  logic [POS_W-1:0]       cmd_thr_r, cmd_thr_nxt;
  logic [SURF_W-1:0]      cmd_surf_r [SURF_N];
  logic [SURF_W-1:0]      cmd_surf_nxt [SURF_N];
  logic [SURF_W-1:0]      trim_r [SURF_N];
  logic [SURF_W-1:0]      trim_nxt [SURF_N];
  logic                   armed_r, armed_nxt;
  logic [TIMER_BITS-1:0]  quiet_r, quiet_nxt, quiet_inc;
  logic                   crit_r, crit_nxt;

  // applied outputs double as the result payload
  logic [POS_W-1:0]       app_thr_r, app_thr_nxt;
  logic [POS_W-1:0]       app_surf_r [SURF_N];
  logic [POS_W-1:0]       app_surf_nxt [SURF_N];

  // per-result flags
  logic                   out_valid_r, out_valid_nxt;
  logic                   fs_r, fs_nxt;
  status_ev_t             ev_r, ev_nxt;
  logic                   lowa_r, lowa_nxt;

  logic                   apply;

  // take the next item when the result slot is free or being drained
  assign q_pop = q_not_empty && (!out_valid_r || out_ready);

  assign quiet_inc = (quiet_r == {TIMER_BITS{1'b1}}) ? quiet_r : quiet_r + 1'b1;

  // execute one item
  always_comb begin
    cmd_thr_nxt  = cmd_thr_r;
    cmd_surf_nxt = cmd_surf_r;
    trim_nxt     = trim_r;
    armed_nxt    = armed_r;
    quiet_nxt    = quiet_r;
    crit_nxt     = crit_r;
    fs_nxt       = fs_r;
    ev_nxt       = ev_r;
    lowa_nxt     = lowa_r;
    apply        = 1'b0;
    if (q_pop) begin
      fs_nxt   = 1'b0;
      ev_nxt   = EV_NONE;
      lowa_nxt = 1'b0;
      unique case (q_item.kind)
        K_REFRESH: begin
          quiet_nxt = '0;
        end
        K_CONTROL: begin
          quiet_nxt   = '0;
          cmd_thr_nxt = q_item.throttle;
          for (int i = 0; i < SURF_N; i++) begin
            cmd_surf_nxt[i] = q_item.vals[i];
          end
          apply = 1'b1;
        end
        K_TRIM: begin
          quiet_nxt = '0;
          for (int i = 0; i < SURF_N; i++) begin
            trim_nxt[i] = q_item.vals[i];
          end
          apply = 1'b1;
        end
        K_ARM: begin
          quiet_nxt = '0;
          if (!armed_r) begin
            armed_nxt = 1'b1;
            ev_nxt    = EV_ARMED;
          end
        end
        K_DISARM: begin
          quiet_nxt = '0;
          if (armed_r) begin
            armed_nxt   = 1'b0;
            cmd_thr_nxt = POS_ZERO;
            apply       = 1'b1;
            ev_nxt      = EV_DISARMED;
          end
        end
        K_TICK: begin
          quiet_nxt = quiet_inc;
          // failsafe: neutral, disarm, re-apply on every late tick
          if (CMP_W'(quiet_inc) > CMP_W'(timeout)) begin
            cmd_thr_nxt = POS_ZERO;
            for (int i = 0; i < SURF_N; i++) begin
              cmd_surf_nxt[i] = SURF_NEUTRAL;
            end
            armed_nxt = 1'b0;
            apply     = 1'b1;
            fs_nxt    = 1'b1;
          end
        end
        K_BATTERY: begin
          crit_nxt = q_item.batt_crit;
          lowa_nxt = q_item.batt_low;
          if (q_item.batt_crit && armed_r) begin
            armed_nxt   = 1'b0;
            cmd_thr_nxt = POS_ZERO;
            apply       = 1'b1;
            ev_nxt      = EV_DISARMED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // re-apply outputs from the updated command state
  always_comb begin
    app_thr_nxt  = app_thr_r;
    app_surf_nxt = app_surf_r;
    if (apply) begin
      app_thr_nxt = armed_nxt ? clamp_thr(cmd_thr_nxt) : POS_ZERO;
      for (int i = 0; i < SURF_N; i++) begin
        app_surf_nxt[i] = clamp180($signed({cmd_surf_nxt[i][SURF_W-1], cmd_surf_nxt[i]}) +
                                   $signed({trim_nxt[i][SURF_W-1], trim_nxt[i]}));
      end
    end
  end

  // result slot handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_thr_r   <= POS_ZERO;
      armed_r     <= 1'b0;
      quiet_r     <= '0;
      crit_r      <= 1'b0;
      app_thr_r   <= POS_ZERO;
      out_valid_r <= 1'b0;
      fs_r        <= 1'b0;
      ev_r        <= EV_NONE;
      lowa_r      <= 1'b0;
      for (int i = 0; i < SURF_N; i++) begin
        cmd_surf_r[i] <= SURF_NEUTRAL;
        trim_r[i]     <= '0;
        app_surf_r[i] <= POS_NEUTRAL;
      end
    end else begin
      cmd_thr_r   <= cmd_thr_nxt;
      armed_r     <= armed_nxt;
      quiet_r     <= quiet_nxt;
      crit_r      <= crit_nxt;
      app_thr_r   <= app_thr_nxt;
      out_valid_r <= out_valid_nxt;
      fs_r        <= fs_nxt;
      ev_r        <= ev_nxt;
      lowa_r      <= lowa_nxt;
      cmd_surf_r  <= cmd_surf_nxt;
      trim_r      <= trim_nxt;
      app_surf_r  <= app_surf_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_throttle_out      = app_thr_r;
  assign out_aileron_out       = app_surf_r[0];
  assign out_elevator_out      = app_surf_r[1];
  assign out_rudder_out        = app_surf_r[2];
  assign out_armed             = armed_r;
  assign out_failsafe_active   = fs_r;
  assign out_status_event      = ev_r;
  assign out_low_battery_alert = lowa_r;
  assign out_battery_critical  = crit_r;

`ifndef SYNTHESIS
  a_disarmed_no_throttle: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> (app_thr_r == POS_ZERO))
    else $error("throttle applied while disarmed");
  a_arm_event_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ev_r == EV_ARMED) |-> armed_r)
    else $error("arm event without armed flag");
  a_failsafe_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && fs_r) |-> (!armed_r && ev_r == EV_NONE))
    else $error("failsafe left block armed");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(app_thr_r) && $stable(ev_r)))
    else $error("stalled result changed");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import scaf_pkg::*;

  localparam int CLK_HALF = 5;
  localparam int RESET_CYCLES = 8;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS = 10;
  localparam int SAT_TICKS = 20;

  // opcodes the block leaves undecoded
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    logic [2:0]              op;
    logic                    chk;
    logic [POS_W-1:0]        thr;
    logic signed [SURF_W-1:0] ail;
    logic signed [SURF_W-1:0] ele;
    logic signed [SURF_W-1:0] rud;
    logic [ADC_W-1:0]        raw;
  } servo_event_t;

  typedef struct packed {
    logic [POS_W-1:0] thr;
    logic [POS_W-1:0] ail;
    logic [POS_W-1:0] ele;
    logic [POS_W-1:0] rud;
    logic             armed;
    logic             failsafe;
    status_ev_t       ev;
    logic             low_alert;
    logic             crit;
  } servo_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_opcode = '0;
  logic in_checksum_ok = 1'b0;
  logic [POS_W-1:0] in_throttle_value = '0;
  logic signed [SURF_W-1:0] in_aileron_value = '0;
  logic signed [SURF_W-1:0] in_elevator_value = '0;
  logic signed [SURF_W-1:0] in_rudder_value = '0;
  logic [ADC_W-1:0] in_battery_raw = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [POS_W-1:0] out_throttle_out;
  logic [POS_W-1:0] out_aileron_out;
  logic [POS_W-1:0] out_elevator_out;
  logic [POS_W-1:0] out_rudder_out;
  logic out_armed;
  logic out_failsafe_active;
  logic [1:0] out_status_event;
  logic out_low_battery_alert;
  logic out_battery_critical;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  servo_command_arming_failsafe dut (.*);

  always #CLK_HALF clk = ~clk;

  // shadow copy of the block's registers and state
  logic [TIMEOUT_W-1:0] fs_timeout;
  logic [ADC_W-1:0] low_thr;
  logic [ADC_W-1:0] crit_thr;
  logic [POS_W-1:0] cmd_thr;
  logic signed [SURF_W-1:0] cmd_surf [SURF_N];
  logic signed [SURF_W-1:0] trim_ofs [SURF_N];
  logic armed_q;
  logic [TIMER_BITS-1:0] quiet_ms;
  logic batt_low;
  logic batt_crit;
  logic [POS_W-1:0] applied_pos [4];

  servo_event_t event_queue[$];
  servo_status_t expected_status[$];
  servo_event_t cur_beat;
  int fail_count = 0;
  int in_gap_pct = 0;
  int out_gap_pct = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int cycles = 0;

  function automatic logic [POS_W-1:0] limit_servo(input int v);
    if (v < 0) return '0;
    if (v > 180) return 8'd180;
    return v[POS_W-1:0];
  endfunction

  function automatic void refresh_outputs();
    applied_pos[0] = armed_q ? limit_servo(int'(cmd_thr)) : '0;
    for (int i = 0; i < SURF_N; i++)
      applied_pos[i + 1] = limit_servo(int'(cmd_surf[i]) + int'(trim_ofs[i]));
  endfunction

  function automatic void disarm_now();
    armed_q = 1'b0;
    cmd_thr = '0;
    refresh_outputs();
  endfunction

  function automatic void reset_shadow();
    fs_timeout = TIMEOUT_RST;
    low_thr = LOW_BATT_RST;
    crit_thr = CRIT_BATT_RST;
    cmd_thr = '0;
    for (int i = 0; i < SURF_N; i++) begin
      cmd_surf[i] = 9'sd90;
      trim_ofs[i] = '0;
    end
    armed_q = 1'b0;
    quiet_ms = '0;
    batt_low = 1'b0;
    batt_crit = 1'b0;
    refresh_outputs();
  endfunction

  // advance the shadow state by one event and return the status it reports
  function automatic servo_status_t apply_event(input servo_event_t e);
    servo_status_t r;
    r.failsafe = 1'b0;
    r.ev = EV_NONE;
    r.low_alert = 1'b0;
    if (e.op <= OP_DISARM) quiet_ms = '0;
    case (e.op)
      OP_CONTROL: begin
        if (e.chk) begin
          cmd_thr = e.thr;
          cmd_surf[0] = e.ail;
          cmd_surf[1] = e.ele;
          cmd_surf[2] = e.rud;
          refresh_outputs();
        end
      end
      OP_TRIM: begin
        trim_ofs[0] = e.ail;
        trim_ofs[1] = e.ele;
        trim_ofs[2] = e.rud;
        refresh_outputs();
      end
      OP_ARM: begin
        if (!armed_q) begin
          armed_q = 1'b1;
          r.ev = EV_ARMED;
        end
      end
      OP_DISARM: begin
        if (armed_q) begin
          disarm_now();
          r.ev = EV_DISARMED;
        end
      end
      OP_TICK: begin
        if (quiet_ms != '1) quiet_ms = quiet_ms + 1'b1;
        if (quiet_ms > fs_timeout) begin
          cmd_thr = '0;
          for (int i = 0; i < SURF_N; i++) cmd_surf[i] = 9'sd90;
          armed_q = 1'b0;
          refresh_outputs();
          r.failsafe = 1'b1;
        end
      end
      OP_BATTERY: begin
        batt_low = e.raw < low_thr;
        batt_crit = e.raw < crit_thr;
        r.low_alert = batt_low;
        if (batt_crit && armed_q) begin
          disarm_now();
          r.ev = EV_DISARMED;
        end
      end
      default: ;
    endcase
    r.thr = applied_pos[0];
    r.ail = applied_pos[1];
    r.ele = applied_pos[2];
    r.rud = applied_pos[3];
    r.armed = armed_q;
    r.crit = batt_crit;
    return r;
  endfunction

  function automatic string show_status(input servo_status_t s);
    return $sformatf("thr=%0d ail=%0d ele=%0d rud=%0d armed=%0b fs=%0b ev=%0d low=%0b crit=%0b",
                     s.thr, s.ail, s.ele, s.rud, s.armed, s.failsafe, s.ev, s.low_alert, s.crit);
  endfunction

  // event sender: one beat per handshake, random idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) expected_status.push_back(apply_event(cur_beat));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (event_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct) begin
          send_gap = $urandom_range(0, 18);
          in_valid <= 1'b0;
        end else begin
          cur_beat = event_queue.pop_front();
          in_valid <= 1'b1;
          in_opcode <= cur_beat.op;
          in_checksum_ok <= cur_beat.chk;
          in_throttle_value <= cur_beat.thr;
          in_aileron_value <= cur_beat.ail;
          in_elevator_value <= cur_beat.ele;
          in_rudder_value <= cur_beat.rud;
          in_battery_raw <= cur_beat.raw;
        end
      end
    end
  end

  // status receiver: compare each beat with the oldest prediction
  always @(posedge clk) begin
    servo_status_t got;
    servo_status_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.thr = out_throttle_out;
        got.ail = out_aileron_out;
        got.ele = out_elevator_out;
        got.rud = out_rudder_out;
        got.armed = out_armed;
        got.failsafe = out_failsafe_active;
        got.ev = status_ev_t'(out_status_event);
        got.low_alert = out_low_battery_alert;
        got.crit = out_battery_critical;
        if (expected_status.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t unexpected status beat: %s", $realtime, show_status(got));
        end else begin
          want = expected_status.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t status mismatch\n  exp %s\n  got %s", $realtime,
                       show_status(want), show_status(got));
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (out_gap_pct > 0 && $urandom_range(0, 99) < out_gap_pct) begin
        recv_stall = $urandom_range(0, 18);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic servo_event_t mk(input logic [2:0] op, input logic chk, input int thr,
                                      input int ail, input int ele, input int rud,
                                      input int raw);
    servo_event_t e;
    e.op = op;
    e.chk = chk;
    e.thr = thr[POS_W-1:0];
    e.ail = ail[SURF_W-1:0];
    e.ele = ele[SURF_W-1:0];
    e.rud = rud[SURF_W-1:0];
    e.raw = raw[ADC_W-1:0];
    return e;
  endfunction

  function automatic int pick_surface();
    if ($urandom_range(0, 1) == 0) return int'($urandom_range(0, 240)) - 30;
    return int'($urandom_range(0, 511)) - 256;
  endfunction

  function automatic int pick_raw();
    int v;
    case ($urandom_range(0, 4))
      0: v = int'(low_thr) + int'($urandom_range(0, 80)) - 40;
      1: v = int'(crit_thr) + int'($urandom_range(0, 80)) - 40;
      2: v = int'(low_thr) - int'($urandom_range(0, 1));
      default: v = int'($urandom_range(0, 4095));
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  // random content around a chosen opcode
  function automatic servo_event_t random_event(input logic [2:0] op);
    servo_event_t e;
    e = mk(op, $urandom_range(0, 9) != 0, $urandom_range(0, 255), pick_surface(),
           pick_surface(), pick_surface(), pick_raw());
    if (op == OP_TRIM && $urandom_range(0, 2) != 0) begin
      e.ail = 9'($signed(int'($urandom_range(0, 40)) - 20));
      e.ele = 9'($signed(int'($urandom_range(0, 40)) - 20));
      e.rud = 9'($signed(int'($urandom_range(0, 40)) - 20));
    end
    return e;
  endfunction

  function automatic logic [2:0] random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return OP_CONTROL;
    if (r < 42) return OP_TRIM;
    if (r < 54) return OP_ARM;
    if (r < 62) return OP_DISARM;
    if (r < 80) return OP_TICK;
    if (r < 95) return OP_BATTERY;
    return ($urandom_range(0, 1) != 0) ? OP_SPARE_7 : OP_SPARE_6;
  endfunction

  // mostly flight-like sequences: arm, commands and tick runs around the timeout
  task automatic queue_random(input int count);
    int n;
    int k;
    int run;
    n = 0;
    while (n < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          event_queue.push_back(random_event(OP_ARM));
          k = $urandom_range(2, 8);
          for (int i = 0; i < k; i++) begin
            case ($urandom_range(0, 5))
              0, 1, 2: event_queue.push_back(random_event(OP_CONTROL));
              3: event_queue.push_back(random_event(OP_TRIM));
              4: event_queue.push_back(random_event(OP_TICK));
              default: event_queue.push_back(random_event(OP_BATTERY));
            endcase
          end
          n += k + 1;
        end
        3, 4: begin
          run = (fs_timeout > 37) ? 40 : int'(fs_timeout) + 3;
          run = $urandom_range(1, run);
          for (int i = 0; i < run; i++) event_queue.push_back(random_event(OP_TICK));
          n += run;
        end
        default: begin
          event_queue.push_back(random_event(random_op()));
          n++;
        end
      endcase
    end
  endtask

  // sender holds off until every status beat is back, then the pipeline drains
  task automatic wait_settled();
    while (event_queue.size() != 0 || in_valid || expected_status.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_TIMEOUT:   fs_timeout = val[TIMEOUT_W-1:0];
      CFG_LOW_BATT:  low_thr = val[ADC_W-1:0];
      CFG_CRIT_BATT: crit_thr = val[ADC_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_all(input int timeout, input int low, input int crit);
    write_reg(CFG_TIMEOUT, timeout[CFG_W-1:0]);
    write_reg(CFG_LOW_BATT, {4'($urandom_range(0, 15)), low[ADC_W-1:0]});
    write_reg(CFG_CRIT_BATT, {4'($urandom_range(0, 15)), crit[ADC_W-1:0]});
    @(negedge clk);
  endtask

  initial begin
    int lo;
    reset_shadow();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset thresholds: clamping, arming, checksum, battery edges
    in_gap_pct = 10;
    out_gap_pct = 10;
    event_queue.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
    event_queue.push_back(mk(OP_CONTROL, 1, 255, -256, 255, 90, 0));
    event_queue.push_back(mk(OP_ARM, 0, 0, 0, 0, 0, 0));
    event_queue.push_back(mk(OP_ARM, 1, 0, 0, 0, 0, 0));
    event_queue.push_back(mk(OP_CONTROL, 1, 255, 0, 180, 181, 0));
    event_queue.push_back(mk(OP_CONTROL, 0, 10, 5, 5, 5, 4095));
    event_queue.push_back(mk(OP_TRIM, 1, 0, 255, -256, -1, 0));
    event_queue.push_back(mk(OP_CONTROL, 1, 181, 1, 179, 90, 0));
    event_queue.push_back(mk(OP_DISARM, 0, 0, 0, 0, 0, 0));
    event_queue.push_back(mk(OP_DISARM, 0, 0, 0, 0, 0, 0));
    event_queue.push_back(random_event(OP_SPARE_6));
    event_queue.push_back(random_event(OP_SPARE_7));
    event_queue.push_back(mk(OP_BATTERY, 0, 0, 0, 0, 0, 4095));
    event_queue.push_back(mk(OP_BATTERY, 0, 0, 0, 0, 0, 2895));
    event_queue.push_back(mk(OP_ARM, 0, 0, 0, 0, 0, 0));
    event_queue.push_back(mk(OP_BATTERY, 0, 0, 0, 0, 0, 2688));
    event_queue.push_back(mk(OP_BATTERY, 0, 0, 0, 0, 0, 2896));
    event_queue.push_back(mk(OP_BATTERY, 0, 0, 0, 0, 0, 2689));
    event_queue.push_back(mk(OP_TRIM, 0, 0, 0, 0, 0, 0));
    queue_random(100);
    wait_settled();

    // timeout of 1, thresholds at opposite extremes
    write_all(1, 0, 4095);
    in_gap_pct = 5;
    out_gap_pct = 20;
    event_queue.push_back(mk(OP_BATTERY, 0, 0, 0, 0, 0, 4095));
    event_queue.push_back(mk(OP_ARM, 0, 0, 0, 0, 0, 0));
    event_queue.push_back(mk(OP_BATTERY, 0, 0, 0, 0, 0, 4094));
    event_queue.push_back(mk(OP_ARM, 0, 0, 0, 0, 0, 0));
    event_queue.push_back(mk(OP_CONTROL, 1, 200, 90, 90, 90, 0));
    event_queue.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
    event_queue.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
    event_queue.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0));
    queue_random(80);
    wait_settled();

    // short random timeout, thresholds near nominal, sender pause midway
    lo = $urandom_range(2500, 3300);
    write_all($urandom_range(2, 10), lo, $urandom_range(2400, lo));
    in_gap_pct = 20;
    out_gap_pct = 5;
    queue_random(75);
    wait_settled();
    queue_random(75);
    wait_settled();

    // longest timeout: every reading below 4095 low, nothing critical
    write_all(65535, 4095, 0);
    in_gap_pct = 0;
    out_gap_pct = 15;
    queue_random(80);
    wait_settled();

    // closing part with no idling, then a quiet run under a timeout near the top
    write_all($urandom_range(10, 40), LOW_BATT_RST, CRIT_BATT_RST);
    in_gap_pct = 0;
    out_gap_pct = 0;
    queue_random(90);
    wait_settled();
    write_all(65534, LOW_BATT_RST, CRIT_BATT_RST);
    event_queue.push_back(mk(OP_CONTROL, 0, 0, 0, 0, 0, 0));
    event_queue.push_back(mk(OP_ARM, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < SAT_TICKS; i++) event_queue.push_back(random_event(OP_TICK));
    wait_settled();
    // timeout at the saturation value never fires
    write_all(65535, LOW_BATT_RST, CRIT_BATT_RST);
    for (int i = 0; i < 10; i++) event_queue.push_back(random_event(OP_TICK));
    event_queue.push_back(random_event(OP_ARM));
    event_queue.push_back(random_event(OP_CONTROL));
    event_queue.push_back(random_event(OP_TICK));
    wait_settled();

    fail_count += expected_status.size();
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
